FILE: sv/wsfr_pkg.sv
// shared types, codes and run tables for the websocket frame receiver
// no dependencies; used by the parser, the emitter, the top level and the checker
package wsfr_pkg;

	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1023;

	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [7:0] HDR_PONG  = 8'h8A;
	localparam logic [7:0] HDR_CLOSE = 8'h88;
	localparam logic [7:0] LEN_ZERO  = 8'h00;
	localparam logic [7:0] LEN_TWO   = 8'h02;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_MASK,
		PH_DATA
	} phase_t;

	typedef enum logic [2:0] {
		KIND_TEXT     = 3'd0,
		KIND_REPLY    = 3'd1,
		KIND_PONG     = 3'd2,
		KIND_CLOSED   = 3'd3,
		KIND_TOO_LONG = 3'd4,
		KIND_UNSUP    = 3'd5
	} kind_t;

	// what one received byte asks the emitter to send
	typedef enum logic [2:0] {
		RUN_TEXT,
		RUN_TOO_LONG,
		RUN_UNSUP,
		RUN_PING,
		RUN_PONG,
		RUN_CLOSE_EMPTY,
		RUN_CLOSE_ECHO
	} run_t;

	typedef struct packed {
		logic        valid;
		run_t        kind;
		logic [7:0]  data;
		logic        last;
		logic [15:0] code;
	} run_desc_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        fend;
		logic [15:0] code;
	} result_t;

	function automatic logic [2:0] run_len(run_t r);
		logic [2:0] n;
		unique case (r)
			RUN_PING:        n = 3'd2;
			RUN_CLOSE_EMPTY: n = 3'd3;
			RUN_CLOSE_ECHO:  n = 3'd5;
			default:         n = 3'd1;
		endcase
		return n;
	endfunction

	function automatic result_t run_result(run_desc_t d, logic [2:0] idx);
		result_t r;
		r = '{kind: KIND_REPLY, data: 8'h00, fend: 1'b0, code: 16'h0000};
		unique case (d.kind)
			RUN_TEXT: begin
				r.kind = KIND_TEXT;
				r.data = d.data;
				r.fend = d.last;
			end
			RUN_TOO_LONG: r.kind = KIND_TOO_LONG;
			RUN_UNSUP:    r.kind = KIND_UNSUP;
			RUN_PONG:     r.kind = KIND_PONG;
			RUN_PING: begin
				if (idx == 3'd0) begin
					r.data = HDR_PONG;
				end else begin
					r.data = LEN_ZERO;
					r.fend = 1'b1;
				end
			end
			RUN_CLOSE_EMPTY: begin
				priority case (idx)
					3'd0: r.data = HDR_CLOSE;
					3'd1: begin
						r.data = LEN_ZERO;
						r.fend = 1'b1;
					end
					default: r.kind = KIND_CLOSED;
				endcase
			end
			RUN_CLOSE_ECHO: begin
				priority case (idx)
					3'd0: r.data = HDR_CLOSE;
					3'd1: r.data = LEN_TWO;
					3'd2: r.data = d.code[15:8];
					3'd3: begin
						r.data = d.code[7:0];
						r.fend = 1'b1;
					end
					default: begin
						r.kind = KIND_CLOSED;
						r.code = d.code;
					end
				endcase
			end
			default: r.kind = KIND_UNSUP;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/wsfr_parser.sv
// header parser, unmasker and frame state for the websocket frame receiver
// depends on wsfr_pkg; hands at most one valid run descriptor per accepted byte to the emitter
module wsfr_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic                 accept,
	input  logic [7:0]           rx_byte,
	output wsfr_pkg::run_desc_t  run
);

	wsfr_pkg::phase_t ph_q, ph_d;
	logic [3:0]  op_q, op_d;
	logic        masked_q, masked_d;
	logic [3:0]  ext_q, ext_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] cb_q, cb_d;
	logic        closed_q, closed_d;
	logic [15:0] max_q;

	logic        len_done, hdr_done, frm_done;
	logic [7:0]  key_byte, dbyte;
	logic [16:0] pos_next;
	logic        last;
	logic        unsup;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= wsfr_pkg::MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= wsfr_pkg::PH_HDR0;
			op_q     <= '0;
			masked_q <= 1'b0;
			ext_q    <= '0;
			len_q    <= '0;
			key_q    <= '0;
			pos_q    <= '0;
			cb_q     <= '0;
			closed_q <= 1'b0;
		end else begin
			ph_q     <= ph_d;
			op_q     <= op_d;
			masked_q <= masked_d;
			ext_q    <= ext_d;
			len_q    <= len_d;
			key_q    <= key_d;
			pos_q    <= pos_d;
			cb_q     <= cb_d;
			closed_q <= closed_d;
		end
	end

	always_comb begin
		unique case (pos_q[1:0])
			2'd0: key_byte = key_q[31:24];
			2'd1: key_byte = key_q[23:16];
			2'd2: key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign dbyte    = masked_q ? (rx_byte ^ key_byte) : rx_byte;
	assign pos_next = {1'b0, pos_q} + 17'd1;
	assign last     = {47'b0, pos_next} >= len_q;
	assign unsup    = (op_q != wsfr_pkg::OP_TEXT) && (op_q != wsfr_pkg::OP_CLOSE) &&
	                  (op_q != wsfr_pkg::OP_PING) && (op_q != wsfr_pkg::OP_PONG);

	always_comb begin
		ph_d     = ph_q;
		op_d     = op_q;
		masked_d = masked_q;
		ext_d    = ext_q;
		len_d    = len_q;
		key_d    = key_q;
		pos_d    = pos_q;
		cb_d     = cb_q;
		closed_d = closed_q;
		len_done = 1'b0;
		hdr_done = 1'b0;
		frm_done = 1'b0;
		run      = '{valid: 1'b0, kind: wsfr_pkg::RUN_TEXT, data: 8'h00, last: 1'b0,
		             code: 16'h0000};

		if (accept && !closed_q) begin
			unique case (ph_q)
				wsfr_pkg::PH_HDR0: begin
					op_d = rx_byte[3:0];
					ph_d = wsfr_pkg::PH_HDR1;
				end
				wsfr_pkg::PH_HDR1: begin
					masked_d = rx_byte[7];
					len_d    = '0;
					if (rx_byte[6:0] == wsfr_pkg::LEN_EXT16) begin
						ext_d = 4'd2;
						ph_d  = wsfr_pkg::PH_EXT;
					end else if (rx_byte[6:0] == wsfr_pkg::LEN_EXT64) begin
						ext_d = 4'd8;
						ph_d  = wsfr_pkg::PH_EXT;
					end else begin
						len_d    = {57'b0, rx_byte[6:0]};
						len_done = 1'b1;
					end
				end
				wsfr_pkg::PH_EXT: begin
					len_d = {len_q[55:0], rx_byte};
					ext_d = ext_q - 4'd1;
					len_done = (ext_d == 4'd0);
				end
				wsfr_pkg::PH_MASK: begin
					key_d = {key_q[23:0], rx_byte};
					ext_d = ext_q - 4'd1;
					hdr_done = (ext_d == 4'd0);
				end
				wsfr_pkg::PH_DATA: begin
					if (op_q == wsfr_pkg::OP_TEXT) begin
						run = '{valid: 1'b1, kind: wsfr_pkg::RUN_TEXT, data: dbyte, last: last,
						        code: 16'h0000};
					end else if (op_q == wsfr_pkg::OP_CLOSE) begin
						if (pos_q == 16'd0) begin
							cb_d[15:8] = dbyte;
						end else if (pos_q == 16'd1) begin
							cb_d[7:0] = dbyte;
						end
					end
					pos_d    = pos_next[15:0];
					frm_done = last;
				end
				default: ph_d = wsfr_pkg::PH_HDR0;
			endcase
		end

		// length known: either collect the mask key or finish the header now
		if (len_done) begin
			if (masked_d) begin
				key_d = '0;
				ext_d = 4'd4;
				ph_d  = wsfr_pkg::PH_MASK;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			pos_d = '0;
			cb_d  = '0;
			if (len_d > {48'b0, max_q}) begin
				closed_d = 1'b1;
				ph_d     = wsfr_pkg::PH_HDR0;
				run.valid = 1'b1;
				run.kind  = wsfr_pkg::RUN_TOO_LONG;
			end else begin
				if (unsup) begin
					run.valid = 1'b1;
					run.kind  = wsfr_pkg::RUN_UNSUP;
				end
				if (len_d == 64'd0) begin
					frm_done = 1'b1;
				end else begin
					ph_d = wsfr_pkg::PH_DATA;
				end
			end
		end

		// end of payload: control frames answer here, text and unsupported are silent
		if (frm_done) begin
			ph_d = wsfr_pkg::PH_HDR0;
			if (op_q == wsfr_pkg::OP_PING) begin
				run.valid = 1'b1;
				run.kind  = wsfr_pkg::RUN_PING;
			end else if (op_q == wsfr_pkg::OP_PONG) begin
				run.valid = 1'b1;
				run.kind  = wsfr_pkg::RUN_PONG;
			end else if (op_q == wsfr_pkg::OP_CLOSE) begin
				run.valid = 1'b1;
				run.kind  = (len_d != 64'd0) ? wsfr_pkg::RUN_CLOSE_ECHO
				                             : wsfr_pkg::RUN_CLOSE_EMPTY;
				run.code  = cb_d;
				closed_d  = 1'b1;
			end
		end
	end

endmodule

FILE: sv/wsfr_emitter.sv
// result register and run sequencer for the websocket frame receiver
// depends on wsfr_pkg; steps through the results of one run, one per cycle while take is high
module wsfr_emitter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  wsfr_pkg::run_desc_t  run,
	output logic                 ready,
	output logic                 valid,
	input  logic                 take,
	output wsfr_pkg::result_t    res,
	output logic                 res_last
);

	logic                valid_q;
	wsfr_pkg::run_desc_t run_q;
	logic [2:0]          idx_q;
	logic                xfer;

	assign res      = wsfr_pkg::run_result(run_q, idx_q);
	assign res_last = (idx_q == (wsfr_pkg::run_len(run_q.kind) - 3'd1));
	assign valid    = valid_q;
	assign xfer     = valid_q && take;
	// a new byte may enter while the final result of the current run transfers
	assign ready    = !valid_q || (take && res_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (accept && run.valid) begin
				valid_q <= 1'b1;
				idx_q   <= '0;
			end else if (xfer) begin
				if (res_last) begin
					valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && run.valid) begin
			run_q <= run;
		end
	end

endmodule

FILE: sv/websocket_frame_receiver.sv
// websocket frame receiver: byte-wide header parse, unmask and control replies
// depends on wsfr_pkg, wsfr_parser and wsfr_emitter
//
// One received byte is taken per cycle; its results appear on the master side in the cycle after
// the transfer, from the emitter's result register. While m_tready is high, a byte that causes
// one result or none never stalls the input. A byte that causes a run of n results (pong reply
// n=2, empty close reply n=3, echoed close reply n=5) holds s_tready low while the emitter steps
// through the run, one result per cycle with m_tready high; the next byte is taken in the cycle
// the last result of the run transfers. While a result waits on m_tready the input is held off.
// After a close or a too-long frame every byte is taken and dropped until reset. max_payload
// (reset 1023) is written via cfg_we/cfg_wdata while the block is idle, a user rule not enforced.
module websocket_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,   // max_payload
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // [7:0] data_byte, [23:8] peer_code, [24] run_end
	output logic        m_tlast,     // frame_end
	output logic [2:0]  m_tuser      // [2:0] out_kind
);

	wsfr_pkg::run_desc_t run;
	wsfr_pkg::result_t   res;
	logic                in_xfer;
	logic                res_last;

	assign in_xfer = s_tvalid && s_tready;

	wsfr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.accept    (in_xfer),
		.rx_byte   (s_tdata),
		.run       (run)
	);

	wsfr_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_xfer),
		.run      (run),
		.ready    (s_tready),
		.valid    (m_tvalid),
		.take     (m_tready),
		.res      (res),
		.res_last (res_last)
	);

	assign m_tdata = {7'b0, res_last, res.code, res.data};
	assign m_tlast = res.fend;
	assign m_tuser = res.kind;

endmodule

FILE: sv/wsfr_checker.sv
// port-level checks for the websocket frame receiver
// depends on wsfr_pkg; bound to websocket_frame_receiver below
module wsfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic [2:0]  m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
		$stable(m_tuser))
		else $error("result changed while stalled");

	// input only stalls behind a pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// frame end only on text or reply bytes
	a_fend_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |->
		(m_tuser == wsfr_pkg::KIND_TEXT) || (m_tuser == wsfr_pkg::KIND_REPLY))
		else $error("frame end on an event");

	// close code only on peer-closed events
	a_code_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != wsfr_pkg::KIND_CLOSED) |-> m_tdata[23:8] == 16'h0000)
		else $error("close code outside a peer-closed event");

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
